// ===== design/ttc_pkg.sv =====
// Package for the thermistor code to temperature block.
// Holds fixed-point constants, divider request types and the controller state type.
// No dependencies.
package ttc_pkg;

    // Table depth default
    localparam int TABLE_DEPTH_DEF = 128;

    // Ratio held as num / RATIO_DEN, num = RATIO_SLOPE*code + RATIO_BIAS
    localparam logic signed [24:0] RATIO_SLOPE = 25'sd10404;
    localparam logic signed [24:0] RATIO_BIAS  = 25'sd1395096;
    localparam logic signed [24:0] RATIO_DEN   = 25'sd8000000;

    // Temperature saturation limits (1/256 degree)
    localparam logic signed [59:0] TEMP_MAX = 60'sd8388607;
    localparam logic signed [59:0] TEMP_MIN = -60'sd8388608;

    // Shared divider widths
    localparam int DIV_NW = 58;
    localparam int DIV_DW = 33;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_REXT    = 2'd0,
        CFG_VREF    = 2'd1,
        CFG_ENTRIES = 2'd2,
        CFG_UNUSED  = 2'd3
    } cfg_index_t;

    // Request to the divider
    typedef struct packed {
        logic              start;
        logic [5:0]        bits;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } div_req_t;

    // Answer from the divider
    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quo;
    } div_rsp_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_RES_GO,
        S_RES_WAIT,
        S_MV_GO,
        S_MV_WAIT,
        S_RD_S,
        S_RD_E,
        S_RD_M,
        S_CAP_M,
        S_CHK,
        S_INT_MUL,
        S_INT_GO,
        S_INT_WAIT,
        S_DONE
    } state_t;

endpackage

// ===== design/thermistor_code_to_temperature_top.sv =====
// Top level of the thermistor code to temperature block.
// Instantiates ttc_ctrl, ttc_table_mem and ttc_div; uses ttc_pkg.
//
//  Channel | Signals                                         | Direction
//  --------+-------------------------------------------------+----------
//  config  | cfg_we, cfg_addr, cfg_wdata                     | in
//  input   | in_valid/in_ready, op, raw_code, sensor_select, | in
//          | entry_index, entry_resistance, entry_temperature|
//  result  | out_valid/out_ready, temperature, resistance,   | out
//          | thermistor_millivolts, sensor_id, invalid       |
//
// A table load (op 0) is taken while idle and gives no result.
// A conversion that interpolates runs the ratio division, the millivolt reciprocal
// multiply, the table search and the interpolation division. The divider runs 45
// and 58 steps; an out-of-range ratio goes from S_PREP straight to S_DONE.
// Reset clears control and sets configuration to its defaults; the table holds nothing until loaded.
// A stalled result sits in the output register; the next item waits for it.
module thermistor_code_to_temperature_top
    import ttc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic signed [10:0] raw_code,
    input  logic               sensor_select,
    input  logic [6:0]         entry_index,
    input  logic [31:0]        entry_resistance,
    input  logic signed [23:0] entry_temperature,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [23:0] temperature,
    output logic [31:0]        resistance,
    output logic [11:0]        thermistor_millivolts,
    output logic               sensor_id,
    output logic               invalid
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [31:0]        mem_wres;
    logic signed [23:0] mem_wtemp;
    logic [AW-1:0]      mem_raddr;
    logic [31:0]        mem_rres;
    logic signed [23:0] mem_rtemp;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    // Sequencer and arithmetic
    ttc_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_we                (cfg_we),
        .cfg_addr              (cfg_addr),
        .cfg_wdata             (cfg_wdata),
        .in_valid              (in_valid),
        .in_ready              (in_ready),
        .op                    (op),
        .raw_code              (raw_code),
        .sensor_select         (sensor_select),
        .entry_index           (entry_index),
        .entry_resistance      (entry_resistance),
        .entry_temperature     (entry_temperature),
        .out_valid             (out_valid),
        .out_ready             (out_ready),
        .temperature           (temperature),
        .resistance            (resistance),
        .thermistor_millivolts (thermistor_millivolts),
        .sensor_id             (sensor_id),
        .invalid               (invalid),
        .mem_we                (mem_we),
        .mem_waddr             (mem_waddr),
        .mem_wres              (mem_wres),
        .mem_wtemp             (mem_wtemp),
        .mem_raddr             (mem_raddr),
        .mem_rres              (mem_rres),
        .mem_rtemp             (mem_rtemp),
        .div_req               (div_req),
        .div_rsp               (div_rsp)
    );

    // Table storage
    ttc_table_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_res  (mem_wres),
        .wr_temp (mem_wtemp),
        .rd_addr (mem_raddr),
        .rd_res  (mem_rres),
        .rd_temp (mem_rtemp)
    );

    // Shared divider
    ttc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule

// ===== design/ttc_table_mem.sv =====
// Table storage: resistance and temperature arrays, one write and one read port.
// Read data is registered. Depends on nothing beyond its parameters.
module ttc_table_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic [31:0]         wr_res,
    input  logic signed [23:0]  wr_temp,
    input  logic [AW-1:0]       rd_addr,
    output logic [31:0]         rd_res,
    output logic signed [23:0]  rd_temp
);

    logic [31:0]        res_mem  [DEPTH];
    logic signed [23:0] temp_mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            res_mem[wr_addr]  <= wr_res;
            temp_mem[wr_addr] <= wr_temp;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_res  <= res_mem[rd_addr];
        rd_temp <= temp_mem[rd_addr];
    end

endmodule

// ===== design/ttc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Uses div_req_t and div_rsp_t from ttc_pkg.
module ttc_div
    import ttc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [5:0]        cnt_reg;
    logic [DIV_NW-1:0] num_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_DW:0]   rem_reg;
    logic [DIV_NW-1:0] quo_reg;

    logic [DIV_DW:0]   rem_sh;
    logic              fits;
    logic [5:0]        bit_idx;

    // One step: shift in next numerator bit, compare and subtract
    always_comb
    begin
        bit_idx = cnt_reg - 6'd1;
        rem_sh  = {rem_reg[DIV_DW-1:0], num_reg[bit_idx]};
        fits    = (rem_sh >= {1'b0, den_reg});
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.bits;
            end
            else if (busy_reg)
            begin
                cnt_reg <= bit_idx;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_reg <= {quo_reg[DIV_NW-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ===== design/ttc_ctrl.sv =====
// Controller: configuration registers, ratio arithmetic, table search and interpolation.
// Uses ttc_pkg; drives ttc_table_mem and ttc_div.
module ttc_ctrl
    import ttc_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic signed [10:0] raw_code,
    input  logic               sensor_select,
    input  logic [6:0]         entry_index,
    input  logic [31:0]        entry_resistance,
    input  logic signed [23:0] entry_temperature,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [23:0] temperature,
    output logic [31:0]        resistance,
    output logic [11:0]        thermistor_millivolts,
    output logic               sensor_id,
    output logic               invalid,
    output logic               mem_we,
    output logic [AW-1:0]      mem_waddr,
    output logic [31:0]        mem_wres,
    output logic signed [23:0] mem_wtemp,
    output logic [AW-1:0]      mem_raddr,
    input  logic [31:0]        mem_rres,
    input  logic signed [23:0] mem_rtemp,
    output div_req_t           div_req,
    input  div_rsp_t           div_rsp
);

    localparam int NW = (AW + 1 > 8) ? AW + 1 : 8;

    // ceil(2^40 / 15625): exact floor division by 15625 for 26-bit operands
    localparam logic [26:0] MV_RECIP = 27'd70368745;

    state_t state_reg, state_next;

    // Configuration
    logic [15:0] rext_reg;
    logic [11:0] vref_reg;
    logic [7:0]  entries_reg;

    // Item and arithmetic registers
    logic signed [24:0] num_reg;
    logic               sel_reg;
    logic [38:0]        prod_reg;
    logic [34:0]        mvp_reg;
    logic [31:0]        res_reg;
    logic [11:0]        mv_reg;
    logic               inv_reg;
    logic signed [23:0] temp_reg;
    logic               first_reg;

    // Search registers
    logic [AW-1:0]      s_reg, e_reg, m_reg;
    logic [31:0]        rs_reg, re_reg, rm_reg;
    logic signed [23:0] ts_reg, te_reg, tm_reg;

    // Interpolation registers
    logic [55:0]        mag_reg;
    logic [31:0]        den_reg;
    logic               neg_reg;

    logic               accept;
    logic               out_load;
    logic signed [24:0] code_ext;
    logic signed [24:0] num_calc;
    logic [22:0]        rest;
    logic               ratio_bad;
    logic [NW-1:0]      n_ext, n_clamp;
    logic [AW-1:0]      span;
    logic [AW-1:0]      new_s, new_e, new_span, new_m;
    logic               go_high;
    logic signed [32:0] dr, x;
    logic signed [24:0] dt;
    logic [32:0]        x_abs, dr_abs;
    logic [24:0]        dt_abs;
    logic               x_neg_eff;
    logic signed [59:0] t_sum;
    logic signed [59:0] q_s;

    // Handshake
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_load = (state_reg == S_DONE) && (!out_valid || out_ready);

    // Ratio numerator and remainder
    always_comb
    begin
        code_ext  = 25'(raw_code);
        num_calc  = code_ext * RATIO_SLOPE + RATIO_BIAS;
        rest      = 23'(RATIO_DEN - num_reg);
        ratio_bad = (num_reg <= 25'sd0) || (num_reg >= RATIO_DEN);
    end

    // Entry count clamped to 2..DEPTH
    always_comb
    begin
        n_ext = NW'(entries_reg);
        if (n_ext < NW'(2))
            n_clamp = NW'(2);
        else if (n_ext > NW'(DEPTH))
            n_clamp = NW'(DEPTH);
        else
            n_clamp = n_ext;
    end

    // Bracket narrowing
    always_comb
    begin
        span     = e_reg - s_reg;
        go_high  = (res_reg > rm_reg);
        new_s    = go_high ? s_reg : m_reg;
        new_e    = go_high ? m_reg : e_reg;
        new_span = new_e - new_s;
        new_m    = (new_span >> 1) + new_s;
    end

    // Interpolation terms
    always_comb
    begin
        dr        = $signed({1'b0, re_reg}) - $signed({1'b0, rs_reg});
        x         = $signed({1'b0, res_reg}) - $signed({1'b0, rs_reg});
        dt        = 25'(te_reg) - 25'(ts_reg);
        x_abs     = x[32] ? 33'(-x) : 33'(x);
        dr_abs    = dr[32] ? 33'(-dr) : 33'(dr);
        dt_abs    = dt[24] ? 25'(-dt) : 25'(dt);
        x_neg_eff = (x[32] != dt[24]) && (x_abs != '0) && (dt_abs != '0);
        q_s       = $signed({2'b00, div_rsp.quo});
        t_sum     = neg_reg ? (60'(ts_reg) - q_s) : (60'(ts_reg) + q_s);
    end

    // Memory ports
    always_comb
    begin
        mem_we    = accept && !op && ({4'b0, entry_index} < 11'(DEPTH));
        mem_waddr = AW'(entry_index);
        mem_wres  = entry_resistance;
        mem_wtemp = entry_temperature;
        unique case (state_reg)
            S_RD_S:  mem_raddr = '0;
            S_RD_E:  mem_raddr = e_reg;
            default: mem_raddr = m_reg;
        endcase
    end

    // Divider requests
    always_comb
    begin
        div_req = '0;
        unique case (state_reg)
            S_RES_GO:
            begin
                div_req.start = 1'b1;
                div_req.bits  = 6'd45;
                div_req.num   = DIV_NW'({prod_reg, 5'b0} + 44'(num_reg[22:0]));
                div_req.den   = DIV_DW'({num_reg[22:0], 1'b0});
            end
            S_INT_GO:
            begin
                div_req.start = 1'b1;
                div_req.bits  = 6'(DIV_NW);
                div_req.num   = DIV_NW'({mag_reg, 1'b0}) + DIV_NW'(den_reg);
                div_req.den   = DIV_DW'({den_reg, 1'b0});
            end
            default: div_req = '0;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (accept && op) state_next = S_PREP;
            S_PREP:     state_next = ratio_bad ? S_DONE : S_RES_GO;
            S_RES_GO:   state_next = S_RES_WAIT;
            S_RES_WAIT: if (div_rsp.done) state_next = S_MV_GO;
            S_MV_GO:    state_next = S_MV_WAIT;
            S_MV_WAIT:  state_next = S_RD_S;
            S_RD_S:     state_next = S_RD_E;
            S_RD_E:     state_next = S_RD_M;
            S_RD_M:     state_next = S_CAP_M;
            S_CAP_M:    state_next = S_CHK;
            S_CHK:
            begin
                priority if (res_reg == rs_reg || res_reg == rm_reg || res_reg == re_reg)
                    state_next = S_DONE;
                else if ((span >> 1) == '0)
                    state_next = S_INT_MUL;
                else if ((new_span >> 1) == '0)
                    state_next = S_INT_MUL;
                else
                    state_next = S_RD_M;
            end
            S_INT_MUL:  state_next = (dr == '0) ? S_DONE : S_INT_GO;
            S_INT_GO:   state_next = S_INT_WAIT;
            S_INT_WAIT: if (div_rsp.done) state_next = S_DONE;
            S_DONE:     if (out_load) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rext_reg    <= 16'd1200;
            vref_reg    <= 12'd1220;
            entries_reg <= 8'd128;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_REXT:    rext_reg    <= cfg_wdata;
                CFG_VREF:    vref_reg    <= cfg_wdata[11:0];
                CFG_ENTRIES: entries_reg <= cfg_wdata[7:0];
                CFG_UNUSED:  ;
                default:     ;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                num_reg <= num_calc;
                sel_reg <= sensor_select;
            end
            S_PREP:
            begin
                prod_reg <= 39'(rext_reg) * 39'(rest);
                inv_reg  <= ratio_bad;
                res_reg  <= '0;
                mv_reg   <= '0;
                temp_reg <= '0;
            end
            S_RES_WAIT:
                if (div_rsp.done)
                    res_reg <= (div_rsp.quo[DIV_NW-1:32] != '0) ? '1 : div_rsp.quo[31:0];
            S_MV_GO:
                mvp_reg <= 35'(vref_reg) * 35'(rest);
            S_MV_WAIT:
            begin
                // 8000000 = 512 * 15625: shift, then reciprocal multiply
                mv_reg    <= 12'((53'(mvp_reg[34:9]) * 53'(MV_RECIP)) >> 40);
                s_reg     <= '0;
                e_reg     <= AW'(n_clamp - NW'(1));
                m_reg     <= AW'(n_clamp >> 1);
                first_reg <= 1'b1;
            end
            S_RD_E:
            begin
                rs_reg <= mem_rres;
                ts_reg <= mem_rtemp;
            end
            S_RD_M:
                if (first_reg)
                begin
                    re_reg    <= mem_rres;
                    te_reg    <= mem_rtemp;
                    first_reg <= 1'b0;
                end
            S_CAP_M:
            begin
                rm_reg <= mem_rres;
                tm_reg <= mem_rtemp;
            end
            S_CHK:
            begin
                priority if (res_reg == rs_reg)
                    temp_reg <= ts_reg;
                else if (res_reg == rm_reg)
                    temp_reg <= tm_reg;
                else if (res_reg == re_reg)
                    temp_reg <= te_reg;
                else if ((span >> 1) != '0)
                begin
                    s_reg <= new_s;
                    e_reg <= new_e;
                    m_reg <= new_m;
                    if (go_high)
                    begin
                        re_reg <= rm_reg;
                        te_reg <= tm_reg;
                    end
                    else
                    begin
                        rs_reg <= rm_reg;
                        ts_reg <= tm_reg;
                    end
                end
            end
            S_INT_MUL:
            begin
                temp_reg <= ts_reg;
                mag_reg  <= 56'(x_abs[31:0]) * 56'(dt_abs[23:0]);
                den_reg  <= dr_abs[31:0];
                neg_reg  <= dr[32] ? !x_neg_eff && (x_abs != '0) && (dt_abs != '0)
                                   : x_neg_eff;
            end
            S_INT_WAIT:
                if (div_rsp.done)
                begin
                    if (t_sum > TEMP_MAX)
                        temp_reg <= 24'sd8388607;
                    else if (t_sum < TEMP_MIN)
                        temp_reg <= -24'sd8388608;
                    else
                        temp_reg <= t_sum[23:0];
                end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (out_load)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            temperature           <= temp_reg;
            resistance            <= res_reg;
            thermistor_millivolts <= mv_reg;
            sensor_id             <= sel_reg;
            invalid               <= inv_reg;
        end
    end

endmodule
